FILE: design/pma_pkg.sv
// Shared types, codes and constants for the page map allocator.
// No dependencies; every other file of the block imports this package.
package pma_pkg;

   // field widths of the request, result and register words
   localparam int OP_W     = 3;
   localparam int FIRST_W  = 10;
   localparam int LEN_W    = 11;
   localparam int CFG_W    = 11;
   localparam int PAGE_W   = 10;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   localparam int DEF_MAX_PAGES = 1024;
   localparam logic [CFG_W-1:0] MANAGED_RST = 11'd1024;

   // request codes
   localparam logic [OP_W-1:0] OP_RESERVE   = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_ANY = 3'd1;
   localparam logic [OP_W-1:0] OP_ALLOC_AT  = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD_REF   = 3'd3;
   localparam logic [OP_W-1:0] OP_DROP_REF  = 3'd4;

   // page byte layout: bit 7 reserved, bits 6..0 reference count
   localparam int          RSV_POS  = 7;
   localparam logic [6:0]  CNT_MASK = 7'h7f;
   localparam logic [7:0]  ONE_REF  = 8'h81;
   localparam logic [7:0]  PAGE_FREE = 8'h00;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [FIRST_W-1:0] first_page;
      logic [LEN_W-1:0]   run_length;
      logic               reserve_bit;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] result_page;
      logic              success;
   } rsp_type;

   // verdict of the page unit on one byte
   typedef struct packed {
      logic [7:0] new_byte;
      logic       is_free;
      logic       bad;
   } alu_type;

endpackage

FILE: design/page_map_allocator_refcount_top.sv
// Top level of the page map allocator: stream ports, register port, output
// register. Depends on pma_pkg, pma_walker (which uses pma_page_alu).
//
// One byte per physical page (bit 7 reserved, bits 6..0 reference count),
// held in a single-port-write, registered-read memory of MAX_PAGES entries.
// After reset the block clears the whole map, one page a cycle, and holds
// req_tready low meanwhile; the register port works throughout. A request
// word is then taken only when the sequencer is idle and is processed
// alone: every page visited is first read from the memory (S_RD) and then
// checked or updated through the shared page unit (S_EV). An
// allocate-anywhere scans the map upward for a free run and then writes
// it; a request rejected on its range goes straight to its result. The
// result word is parked in an output register, so a new request word is
// accepted while the previous result waits.
module page_map_allocator_refcount_top #(
   parameter int MAX_PAGES = pma_pkg::DEF_MAX_PAGES
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // first_page[9:0], run_length[20:10],
                                                  // reserve_bit[21], zero fill
   input  logic [2:0]                 req_tuser,  // operation[2:0]
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,  // result_page[9:0], success[10], zero fill
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [pma_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [pma_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [pma_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import pma_pkg::*;

   logic [CFG_W-1:0] managed_ff;
   logic             csr_wr;
   logic             cmd_ready, res_valid, out_free;
   req_type          cmd;
   rsp_type          res;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   // register port: managed_pages is the only register, at byte address 0
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff <= MANAGED_RST;
      end else if (csr_wr && !csr_paddr[2]) begin
         managed_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DW'(managed_ff);

   // unpack the request word
   assign cmd.operation   = req_tuser;
   assign cmd.first_page  = req_tdata[9:0];
   assign cmd.run_length  = req_tdata[20:10];
   assign cmd.reserve_bit = req_tdata[21];

   pma_walker #(
      .MAX_PAGES (MAX_PAGES)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .managed_pages (managed_ff),
      .cmd_valid     (req_tvalid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .res_valid     (res_valid),
      .res_take      (out_free),
      .res           (res)
   );

   assign req_tready = cmd_ready;

   // output register: loads whenever it is empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.success, rsp_data_ff.result_page};

   // a taken request word leaves the sequencer busy in the next cycle
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while sequencer still busy");

   // the map clear runs straight after reset
   a_clear_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request port open during map clear");

   // a failed request never reports a page
   a_fail_page_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[10]) |-> (rsp_tdata[9:0] == '0))
      else $error("failed request reports a non-zero page");

endmodule

FILE: design/pma_page_alu.sv
// Shared page unit: checks one page byte and forms its updated value.
// Depends on pma_pkg.
module pma_page_alu (
   input  logic [pma_pkg::OP_W-1:0] operation,
   input  logic                     reserve_bit,
   input  logic [7:0]               page_byte,
   output pma_pkg::alu_type         verdict
);
   import pma_pkg::*;

   logic [6:0] cnt;

   assign cnt = page_byte[6:0];

   always_comb begin
      verdict.is_free  = (page_byte == PAGE_FREE);
      verdict.new_byte = page_byte;
      verdict.bad      = 1'b0;
      case (operation)
         OP_RESERVE: begin
            verdict.new_byte = page_byte | {reserve_bit, 7'd0};
         end
         OP_ALLOC_ANY, OP_ALLOC_AT: begin
            verdict.new_byte = ONE_REF;
            verdict.bad      = (page_byte != PAGE_FREE);
         end
         OP_ADD_REF: begin
            verdict.new_byte = {1'b1, cnt + 7'd1};
            verdict.bad      = (page_byte == PAGE_FREE) || (cnt == CNT_MASK);
         end
         OP_DROP_REF: begin
            if (page_byte == ONE_REF) begin
               verdict.new_byte = PAGE_FREE;
            end else if (cnt == 7'd0) begin
               verdict.new_byte = page_byte;
            end else begin
               verdict.new_byte = {1'b1, cnt - 7'd1};
            end
         end
         default: begin
            verdict.bad = 1'b1;
         end
      endcase
   end

endmodule

FILE: design/pma_walker.sv
// Sequencer and page store: clears the map after reset, then walks it page
// by page through the shared page unit. Depends on pma_pkg, pma_page_alu.
module pma_walker #(
   parameter int MAX_PAGES = pma_pkg::DEF_MAX_PAGES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [pma_pkg::CFG_W-1:0] managed_pages,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  pma_pkg::req_type          cmd,
   output logic                      res_valid,
   input  logic                      res_take,
   output pma_pkg::rsp_type          res
);
   import pma_pkg::*;

   localparam int PW = $clog2(MAX_PAGES);
   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam int NW = (CW > CFG_W) ? CW : CFG_W;
   localparam int AW = NW + 1;

   typedef enum logic [4:0] {
      S_CLR  = 5'b00001,
      S_IDLE = 5'b00010,
      S_RD   = 5'b00100,
      S_EV   = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  cur_ff, cur_in;
   logic [AW-1:0]  lim_ff, lim_in;
   logic [AW-1:0]  run_ff, run_in;
   logic [AW-1:0]  start_ff, start_in;
   logic           scan_ff, scan_in;
   logic           ok_ff, ok_in;
   req_type        cmd_ff, cmd_in;

   logic [7:0]     mem_ff [MAX_PAGES];
   logic [7:0]     rdata_ff;
   logic           wr_en;
   logic [7:0]     wr_data;

   logic [AW-1:0]  n_w, f_w, l_w, e_w, rsv_lim, cur_nx, run_nx, len_w;
   logic           rng_ok;
   alu_type        verdict;

   pma_page_alu u_alu (
      .operation   (cmd_ff.operation),
      .reserve_bit (cmd_ff.reserve_bit),
      .page_byte   (rdata_ff),
      .verdict     (verdict)
   );

   // live page count and range checks on the incoming word
   assign n_w = (AW'(managed_pages) < AW'(MAX_PAGES)) ? AW'(managed_pages) : AW'(MAX_PAGES);
   assign f_w     = AW'(cmd.first_page);
   assign l_w     = AW'(cmd.run_length);
   assign e_w     = f_w + l_w;
   assign rsv_lim = (e_w < n_w) ? e_w : n_w;
   assign rng_ok  = (l_w != '0) && (f_w < n_w) && (e_w <= n_w);

   assign cur_nx = cur_ff + AW'(1);
   assign run_nx = run_ff + AW'(1);
   assign len_w  = AW'(cmd_ff.run_length);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      lim_in   = lim_ff;
      run_in   = run_ff;
      start_in = start_ff;
      scan_in  = scan_ff;
      ok_in    = ok_ff;
      cmd_in   = cmd_ff;
      wr_en    = 1'b0;
      wr_data  = verdict.new_byte;
      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_data = PAGE_FREE;
            cur_in  = cur_nx;
            if (cur_ff == AW'(MAX_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               ok_in    = 1'b0;
               start_in = '0;
               run_in   = '0;
               state_in = S_DONE;
               case (cmd.operation)
                  OP_RESERVE: begin
                     if (l_w != '0) begin
                        ok_in   = 1'b1;
                        cur_in  = f_w;
                        lim_in  = rsv_lim;
                        scan_in = 1'b0;
                        if (f_w < rsv_lim) begin
                           state_in = S_RD;
                        end
                     end
                  end
                  OP_ALLOC_ANY: begin
                     if ((l_w != '0) && (n_w > AW'(1))) begin
                        cur_in   = AW'(1);
                        lim_in   = n_w;
                        scan_in  = 1'b1;
                        state_in = S_RD;
                     end
                  end
                  OP_ALLOC_AT, OP_ADD_REF: begin
                     if (rng_ok) begin
                        cur_in   = f_w;
                        lim_in   = e_w;
                        scan_in  = 1'b1;
                        state_in = S_RD;
                        if (cmd.operation == OP_ALLOC_AT) begin
                           start_in = f_w;
                        end
                     end
                  end
                  OP_DROP_REF: begin
                     if (rng_ok) begin
                        cur_in   = f_w;
                        lim_in   = e_w;
                        scan_in  = 1'b0;
                        ok_in    = 1'b1;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (scan_ff) begin
               if (cmd_ff.operation == OP_ALLOC_ANY) begin
                  run_in = verdict.is_free ? run_nx : '0;
                  if (verdict.is_free && (run_nx == len_w)) begin
                     start_in = cur_nx - len_w;
                     cur_in   = cur_nx - len_w;
                     lim_in   = cur_nx;
                     scan_in  = 1'b0;
                     state_in = S_RD;
                  end else if (cur_nx < lim_ff) begin
                     cur_in   = cur_nx;
                     state_in = S_RD;
                  end else begin
                     ok_in    = 1'b0;
                     state_in = S_DONE;
                  end
               end else if (verdict.bad) begin
                  ok_in    = 1'b0;
                  state_in = S_DONE;
               end else if (cur_nx < lim_ff) begin
                  cur_in   = cur_nx;
                  state_in = S_RD;
               end else begin
                  cur_in   = AW'(cmd_ff.first_page);
                  scan_in  = 1'b0;
                  state_in = S_RD;
               end
            end else begin
               wr_en = 1'b1;
               if (cur_nx < lim_ff) begin
                  cur_in   = cur_nx;
                  state_in = S_RD;
               end else begin
                  ok_in    = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cur_ff   <= '0;
         scan_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         scan_ff  <= scan_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      run_ff   <= run_in;
      start_ff <= start_in;
      cmd_ff   <= cmd_in;
   end

   // page store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[cur_ff[PW-1:0]] <= wr_data;
      end
      rdata_ff <= mem_ff[cur_ff[PW-1:0]];
   end

   assign cmd_ready       = (state_ff == S_IDLE);
   assign res_valid       = (state_ff == S_DONE);
   assign res.result_page = ok_ff ? PAGE_W'(start_ff) : '0;
   assign res.success     = ok_ff;

endmodule
